// ----- rtl/pkq_pkg.sv -----
// ============================================================================
// Priority key queue package
// Shared constants, request and register codes, and the command and status
// records that pass between the controller and the datapath.
// ============================================================================
package pkq_pkg;

    // Default number of queue entries.
    localparam int unsigned QUEUE_DEPTH_DEF = 16;

    // Field widths.
    localparam int unsigned KEY_W      = 4;
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned OCC_W      = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 16;

    // Largest key that counts as a decimal digit.
    localparam logic [KEY_W-1:0] MAX_DIGIT = 4'd9;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_KEY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_KEY     = 2'd2;

    // Register reset values.
    localparam logic             ACTIVE_RST       = 1'b0;
    localparam logic [KEY_W-1:0] PRIORITY_KEY_RST = 4'd3;
    localparam logic [KEY_W-1:0] IDLE_KEY_RST     = 4'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_in;       // capture the accepted word, clear the result
        logic enq_wr;      // write the key at the tail
        logic fill_inc;
        logic fill_dec;
        logic fill_clr;
        logic drop_set;
        logic tkey_idle;   // result key is the idle key
        logic idx_clr;
        logic ram_rd;      // read the entry at the index
        logic scan_cmp;    // compare the read entry, remember the head
        logic take_match;  // take the read entry, shifting starts behind it
        logic take_head;   // take the head entry, shifting starts at one
        logic idx_inc;
        logic shift_wr;    // move the read entry down by one place
        logic res_load;    // load the output register
    } pkq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic key_digit;
        logic full;
        logic empty;
        logic active;
        logic match;
        logic idx_last;    // index is the last queued entry
        logic idx_end;     // index is past the last queued entry
        logic out_free;    // output register can take a new word
    } pkq_status_t;

endpackage

// ----- rtl/priority_key_queue_core.sv -----
// ============================================================================
// Priority key queue core
// Ordered queue of decimal-digit keys with a bypass for one priority key.
// ============================================================================
// Usage: requests arrive as words on the s_axis channel (enqueue, dequeue or
// flush) and each produces exactly one result word on the m_axis channel,
// carrying the dequeued key, the drop flag and the occupancy after the
// request. Three registers (active, priority_key, idle_key) are written on
// the cfg channel, which is always ready; write them only while no request
// is in flight.
// Sequence: an enqueue, flush, ignored request or a dequeue that needs no
// search goes from the dispatch state to the finish state, where its result
// is loaded. A dequeue on a non-empty, active queue scans the entry RAM,
// reading then comparing each entry, until it finds the oldest priority key
// or reaches the last entry and takes the head; it then moves each entry
// behind the removed one down by one place. The single-port-per-direction
// RAM's registered read puts a read state before each compare or shift
// write. The next request is accepted on the cycle after the result loads.
// Reset empties the queue (fill count to zero) and loads the registers with
// active 0, priority_key 3 and idle_key 1; no clearing pass is needed.
// Stall: a result word waits in the output register while the next request
// is taken and worked on; only the loading of the following result waits.
// ============================================================================
module priority_key_queue_core #(
    parameter int unsigned QUEUE_DEPTH = pkq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Request channel.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [1:0] req_type, [5:2] key, [7:6] zero.
    input  logic [pkq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result channel.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: [3:0] out_key, [4] dropped, [9:5] occupancy, [15:10] zero.
    output logic [pkq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pkq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pkq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import pkq_pkg::*;

    pkq_cmd_t    cmd;
    pkq_status_t status;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    pkq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pkq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // The controller goes busy right after it takes a request.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request channel still ready after an accept");

    // A dropped key never comes with a dequeued key.
    a_drop_no_key: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:0] == '0)
        else $error("dropped result carries a key");

    // The tail write and the shift write never share the RAM write port.
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enq_wr && cmd.shift_wr))
        else $error("enqueue and shift write in the same cycle");

    // The queue is never seen full and empty at once.
    a_fill_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.full && status.empty))
        else $error("fill count reads both full and empty");
`endif

endmodule

// ----- rtl/pkq_ram.sv -----
// ============================================================================
// Priority key queue RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ============================================================================
module pkq_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/pkq_datapath.sv -----
// ============================================================================
// Priority key queue datapath
// Registers, entry store, fill count, scan index and output register.
// ============================================================================
module pkq_datapath #(
    parameter int unsigned QUEUE_DEPTH = pkq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pkq_pkg::pkq_cmd_t                   cmd,
    output pkq_pkg::pkq_status_t                status,
    input  logic [pkq_pkg::IN_DATA_W-1:0]       in_data,
    input  logic                                cfg_we,
    input  logic [pkq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pkq_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pkq_pkg::OUT_DATA_W-1:0]      out_data
);

    import pkq_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned PAD_W = OUT_DATA_W - KEY_W - 1 - OCC_W;

    logic [REQ_W-1:0] req_reg;
    logic [KEY_W-1:0] key_reg;
    logic             active_reg;
    logic [KEY_W-1:0] prio_reg;
    logic [KEY_W-1:0] idle_reg;
    logic [CW-1:0]    fill_reg;
    logic [CW-1:0]    idx_reg;
    logic [KEY_W-1:0] head_reg;
    logic [KEY_W-1:0] tkey_reg;
    logic             drop_reg;
    logic             out_valid_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic             out_drop_reg;
    logic [OCC_W-1:0] out_occ_reg;

    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    idx_dec;
    logic [KEY_W-1:0] rd_data;
    logic [KEY_W-1:0] head_val;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);
    // The head is still on the read port when the index is at zero.
    assign head_val = (idx_reg == '0) ? rd_data : head_reg;

    // Enqueue writes the tail; a shift moves an entry down by one place.
    assign wr_en   = cmd.enq_wr | cmd.shift_wr;
    assign wr_addr = cmd.enq_wr ? fill_reg[AW-1:0] : idx_dec[AW-1:0];
    assign wr_data = cmd.enq_wr ? key_reg : rd_data;

    pkq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        status.req       = req_reg;
        status.key_digit = (key_reg <= MAX_DIGIT);
        status.full      = (fill_reg == CW'(QUEUE_DEPTH));
        status.empty     = (fill_reg == '0);
        status.active    = active_reg;
        status.match     = (rd_data == prio_reg);
        status.idx_last  = (idx_inc >= fill_reg);
        status.idx_end   = (idx_reg >= fill_reg);
        status.out_free  = ~out_valid_reg | out_ready;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RST;
            prio_reg   <= PRIORITY_KEY_RST;
            idle_reg   <= IDLE_KEY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE:       active_reg <= cfg_data[0];
                CFG_PRIORITY_KEY: prio_reg   <= cfg_data;
                CFG_IDLE_KEY:     idle_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Fill count and scan index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            if (cmd.fill_clr)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_inc)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            else if (cmd.fill_dec)
            begin
                fill_reg <= fill_reg - CW'(1);
            end

            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.take_head)
            begin
                idx_reg <= CW'(1);
            end
            else if (cmd.take_match || cmd.idx_inc)
            begin
                idx_reg <= idx_inc;
            end
        end
    end

    // Item payload and the result being built.
    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            req_reg  <= in_data[REQ_W-1:0];
            key_reg  <= in_data[REQ_W +: KEY_W];
            tkey_reg <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            if (cmd.drop_set)
            begin
                drop_reg <= 1'b1;
            end
            if (cmd.tkey_idle)
            begin
                tkey_reg <= idle_reg;
            end
            else if (cmd.take_match)
            begin
                tkey_reg <= rd_data;
            end
            else if (cmd.take_head)
            begin
                tkey_reg <= head_val;
            end
        end
        if (cmd.scan_cmp && (idx_reg == '0))
        begin
            head_reg <= rd_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_key_reg  <= tkey_reg;
            out_drop_reg <= drop_reg;
            out_occ_reg  <= OCC_W'(fill_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{PAD_W{1'b0}}, out_occ_reg, out_drop_reg, out_key_reg};

endmodule

// ----- rtl/pkq_ctrl.sv -----
// ============================================================================
// Priority key queue controller
// State machine that sequences enqueue, flush and the dequeue scan and shift.
// ============================================================================
module pkq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pkq_pkg::pkq_status_t status,
    output pkq_pkg::pkq_cmd_t    cmd
);

    import pkq_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_SRD  = 3'd2;
    localparam logic [2:0] ST_SCMP = 3'd3;
    localparam logic [2:0] ST_HRD  = 3'd4;
    localparam logic [2:0] ST_HWR  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_in  = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = ST_FIN;
                case (status.req)
                    REQ_ENQUEUE:
                    begin
                        if (status.key_digit)
                        begin
                            if (status.full)
                            begin
                                cmd.drop_set = 1'b1;
                            end
                            else
                            begin
                                cmd.enq_wr   = 1'b1;
                                cmd.fill_inc = 1'b1;
                            end
                        end
                    end
                    REQ_DEQUEUE:
                    begin
                        if (status.active)
                        begin
                            if (status.empty)
                            begin
                                cmd.tkey_idle = 1'b1;
                            end
                            else
                            begin
                                cmd.idx_clr = 1'b1;
                                state_next  = ST_SRD;
                            end
                        end
                    end
                    REQ_FLUSH:
                    begin
                        cmd.fill_clr = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SRD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (status.match)
                begin
                    cmd.take_match = 1'b1;
                    state_next     = ST_HRD;
                end
                else if (status.idx_last)
                begin
                    cmd.take_head = 1'b1;
                    state_next    = ST_HRD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRD;
                end
            end
            ST_HRD:
            begin
                if (status.idx_end)
                begin
                    cmd.fill_dec = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.ram_rd = 1'b1;
                    state_next = ST_HWR;
                end
            end
            ST_HWR:
            begin
                cmd.shift_wr = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = ST_HRD;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
